/* hdl/ttisu_pkg.sv */
// ----------------------------------------------------------------------------
// ttisu_pkg
// types and constants shared by the tone, timer and interrupt sound unit
// ----------------------------------------------------------------------------
`default_nettype none

package ttisu_pkg;

  localparam logic [1:0] CMD_TICK      = 2'd0;
  localparam logic [1:0] CMD_REG_WRITE = 2'd1;
  localparam logic [1:0] CMD_IRQ_EN    = 2'd2;
  localparam logic [1:0] CMD_VIDEO     = 2'd3;

  localparam logic [4:0] OFF_TONE_CTRL = 5'd7;
  localparam logic [4:0] OFF_FAST_CLK  = 5'd31;

  localparam logic [1:0] SEL_KHZ   = 2'd0;
  localparam logic [1:0] SEL_FIFTY = 2'd1;
  localparam logic [1:0] SEL_TONE0 = 2'd2;
  localparam logic [1:0] SEL_TONE1 = 2'd3;

  localparam int unsigned KhzReload   = 250 - 1;
  localparam int unsigned FiftyReload = 5000 - 1;
  localparam int unsigned OneHzReload = 250000 - 1;

  localparam int unsigned KHZ_W   = $clog2(KhzReload + 1);
  localparam int unsigned FIFTY_W = $clog2(FiftyReload + 1);
  localparam int unsigned ONEHZ_W = $clog2(OneHzReload + 1);

  localparam logic [2:0] SAMPLE_RELOAD_FAST = 3'd3;
  localparam logic [2:0] SAMPLE_RELOAD_SLOW = 3'd5;

  typedef struct packed {
    logic [1:0] command;
    logic [4:0] reg_offset;
    logic [7:0] write_data;
    logic       video_level;
  } in_item_t;

  typedef struct packed {
    logic       sample_valid;
    logic [7:0] left_sample;
    logic [7:0] right_sample;
    logic [5:0] int_status;
  } out_item_t;

endpackage

`default_nettype wire

/* hdl/tone_timer_interrupt_sound_unit.sv */
// ----------------------------------------------------------------------------
// tone_timer_interrupt_sound_unit
// tone, timer and interrupt sound unit with valid/stall channels
// ----------------------------------------------------------------------------
// Each input transaction (tick, register write, interrupt enable write or
// video line change) is applied to the unit state in the cycle it is accepted
// and yields exactly one registered result transaction. One transaction
// is taken every cycle; the only limit is the result register plus one skid
// entry, so in_stall rises only when the result side has stalled for two
// items. A sample is produced on every sixth tick, or fourth in fast clock
// mode, while sample_enable is set. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module tone_timer_interrupt_sound_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ttisu_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ttisu_pkg::out_item_t      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_data
);
  import ttisu_pkg::*;

  logic      accept;
  logic      full;
  out_item_t result;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  ttisu_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .item_we  (accept),
    .item     (in_data),
    .result   (result)
  );

  ttisu_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* hdl/ttisu_core.sv */
// ----------------------------------------------------------------------------
// ttisu_core
// unit state: dividers, tone counters, registers and interrupt flags, updated
// once per accepted transaction, with the matching result formed alongside
// ----------------------------------------------------------------------------
`default_nettype none

module ttisu_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_data,
  input  wire logic               item_we,
  input  wire ttisu_pkg::in_item_t  item,
  output ttisu_pkg::out_item_t    result
);
  import ttisu_pkg::*;

  logic                 sample_en_r;
  logic [11:0]          reload_r [3];
  logic [11:0]          count_r  [3];
  logic [2:0]           flip_r;
  logic [5:0]           vol_r    [8];
  logic [6:0]           tctrl_r;
  logic                 fast_r;
  logic [KHZ_W-1:0]     khz_r;
  logic [FIFTY_W-1:0]   fifty_r;
  logic [ONEHZ_W-1:0]   onehz_r;
  logic [2:0]           sdiv_r;
  logic [5:0]           flags_r;
  logic [7:0]           en_r;

  logic [11:0]          count_nxt [3];
  logic [2:0]           flip_nxt;
  logic [2:0]           tone_fire;
  logic [KHZ_W-1:0]     khz_nxt;
  logic [FIFTY_W-1:0]   fifty_nxt;
  logic [ONEHZ_W-1:0]   onehz_nxt;
  logic [2:0]           sdiv_nxt;
  logic [5:0]           flags_nxt;
  logic                 khz_fire;
  logic                 fifty_fire;
  logic                 onehz_fire;
  logic                 tone_evt;
  logic                 sample_fire;
  logic [7:0]           left_mix;
  logic [7:0]           right_mix;

  // tone counters
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tone_fire[i] = 1'b0;
      if (tctrl_r[i]) begin
        count_nxt[i] = reload_r[i];
        flip_nxt[i]  = 1'b0;
      end else if (count_r[i] == 12'd0) begin
        count_nxt[i] = reload_r[i];
        flip_nxt[i]  = ~flip_r[i];
        tone_fire[i] = 1'b1;
      end else begin
        count_nxt[i] = count_r[i] - 12'd1;
        flip_nxt[i]  = flip_r[i];
      end
    end
  end

  assign khz_fire   = (khz_r == '0);
  assign fifty_fire = (fifty_r == '0);
  assign onehz_fire = (onehz_r == '0);
  assign khz_nxt    = khz_fire ? KHZ_W'(KhzReload) : khz_r - KHZ_W'(1);
  assign fifty_nxt  = fifty_fire ? FIFTY_W'(FiftyReload) : fifty_r - FIFTY_W'(1);
  assign onehz_nxt  = onehz_fire ? ONEHZ_W'(OneHzReload) : onehz_r - ONEHZ_W'(1);

  always_comb begin
    case (tctrl_r[6:5])
      SEL_KHZ:   tone_evt = khz_fire;
      SEL_FIFTY: tone_evt = fifty_fire;
      SEL_TONE0: tone_evt = tone_fire[0];
      SEL_TONE1: tone_evt = tone_fire[1];
      default:   tone_evt = 1'b0;
    endcase
  end

  assign sample_fire = sample_en_r && (sdiv_r == 3'd0);
  always_comb begin
    if (!sample_en_r) begin
      sdiv_nxt = sdiv_r;
    end else if (sdiv_r == 3'd0) begin
      sdiv_nxt = fast_r ? SAMPLE_RELOAD_FAST : SAMPLE_RELOAD_SLOW;
    end else begin
      sdiv_nxt = sdiv_r - 3'd1;
    end
  end

  // mix uses the flip-flops after this tick
  always_comb begin
    if (tctrl_r[3]) begin
      left_mix = {vol_r[0], 2'b00};
    end else begin
      left_mix = ({2'b00, vol_r[0] & {6{flip_nxt[0]}}})
               + ({2'b00, vol_r[1] & {6{flip_nxt[1]}}})
               + ({2'b00, vol_r[2] & {6{flip_nxt[2]}}});
    end
    if (tctrl_r[4]) begin
      right_mix = {vol_r[4], 2'b00};
    end else begin
      right_mix = ({2'b00, vol_r[4] & {6{flip_nxt[0]}}})
                + ({2'b00, vol_r[5] & {6{flip_nxt[1]}}})
                + ({2'b00, vol_r[6] & {6{flip_nxt[2]}}});
    end
  end

  // interrupt flags
  always_comb begin
    flags_nxt = flags_r;
    unique case (item.command)
      CMD_TICK: begin
        flags_nxt[0] = flags_r[0] ^ tone_evt;
        flags_nxt[1] = flags_r[1] | (tone_evt & en_r[0]);
        flags_nxt[2] = flags_r[2] ^ onehz_fire;
        flags_nxt[3] = flags_r[3] | (onehz_fire & en_r[2]);
      end
      CMD_REG_WRITE: begin
        flags_nxt = flags_r;
      end
      CMD_IRQ_EN: begin
        for (int j = 0; j < 3; j++) begin
          flags_nxt[2*j+1] = flags_r[2*j+1] & ~item.write_data[2*j+1]
                           & item.write_data[2*j];
        end
      end
      CMD_VIDEO: begin
        if (item.video_level) begin
          flags_nxt[4] = 1'b1;
        end else begin
          flags_nxt[5] = flags_r[5] | (flags_r[4] & en_r[4]);
          flags_nxt[4] = 1'b0;
        end
      end
      default: flags_nxt = flags_r;
    endcase
  end

  always_comb begin
    result = '0;
    result.int_status = flags_nxt;
    if (item.command == CMD_TICK && sample_fire) begin
      result.sample_valid = 1'b1;
      result.left_sample  = left_mix;
      result.right_sample = right_mix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_en_r <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        reload_r[i] <= '0;
        count_r[i]  <= '0;
      end
      for (int k = 0; k < 8; k++) begin
        vol_r[k] <= '0;
      end
      flip_r  <= '0;
      tctrl_r <= '0;
      fast_r  <= 1'b0;
      khz_r   <= '0;
      fifty_r <= '0;
      onehz_r <= '0;
      sdiv_r  <= '0;
      flags_r <= '0;
      en_r    <= '0;
    end else begin
      if (cfg_we) begin
        sample_en_r <= cfg_data;
      end
      if (item_we) begin
        flags_r <= flags_nxt;
        unique case (item.command)
          CMD_TICK: begin
            for (int i = 0; i < 3; i++) begin
              count_r[i] <= count_nxt[i];
            end
            flip_r  <= flip_nxt;
            khz_r   <= khz_nxt;
            fifty_r <= fifty_nxt;
            onehz_r <= onehz_nxt;
            sdiv_r  <= sdiv_nxt;
          end
          CMD_REG_WRITE: begin
            if (item.reg_offset < 5'd6) begin
              if (item.reg_offset[0]) begin
                reload_r[item.reg_offset[2:1]][11:8] <= item.write_data[3:0];
              end else begin
                reload_r[item.reg_offset[2:1]][7:0] <= item.write_data;
              end
            end else if (item.reg_offset == OFF_TONE_CTRL) begin
              tctrl_r <= item.write_data[6:0];
            end else if (item.reg_offset[4:3] == 2'b01) begin
              vol_r[item.reg_offset[2:0]] <= item.write_data[5:0];
            end else if (item.reg_offset == OFF_FAST_CLK) begin
              fast_r <= item.write_data[1];
            end
          end
          CMD_IRQ_EN: begin
            en_r <= item.write_data;
          end
          CMD_VIDEO: begin
            en_r <= en_r;
          end
          default: en_r <= en_r;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/ttisu_skid.sv */
// ----------------------------------------------------------------------------
// ttisu_skid
// result register with one skid entry between the unit and the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module ttisu_skid (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire ttisu_pkg::out_item_t  push_data,
  output logic                     full,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ttisu_pkg::out_item_t     out_data
);
  import ttisu_pkg::*;

  logic      out_valid_r;
  out_item_t out_r;
  logic      skid_valid_r;
  out_item_t skid_r;
  logic      room;

  assign room      = !out_valid_r || !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (room) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (room) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (push) begin
        out_r <= push_data;
      end
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule

`default_nettype wire

/* tb/ttisu_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttisu_result_checker
// predicts and checks every result of the tone, timer and interrupt unit
// ----------------------------------------------------------------------------
// Watches the input, result and configuration channels. Each accepted input
// transaction is applied to a private copy of the unit state (dividers, tone
// counters, interrupt flags, audio registers), and the predicted result is
// queued. Each accepted result transaction is compared field by field with
// the oldest queued prediction. The mismatch count and the number of results
// still due are handed to the testbench top.
// ----------------------------------------------------------------------------

module ttisu_result_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  ttisu_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  ttisu_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic                 cfg_data,
  output int                   fail_count,
  output int                   pending
);
  import ttisu_pkg::*;

  localparam int IRQ_TONE_LVL  = 0;
  localparam int IRQ_TONE_LAT  = 1;
  localparam int IRQ_ONEHZ_LVL = 2;
  localparam int IRQ_ONEHZ_LAT = 3;
  localparam int IRQ_VIDEO_LVL = 4;
  localparam int IRQ_VIDEO_LAT = 5;

  localparam logic [4:0] OFF_TONE_END  = 5'd6;
  localparam logic [4:0] OFF_VOL_FIRST = 5'd8;
  localparam logic [4:0] OFF_VOL_END   = 5'd16;

  logic        sample_en;
  logic [11:0] tone_reload [3];
  logic [12:0] tone_count [3];
  logic        tone_flip [3];
  logic [5:0]  volume [8];
  logic [6:0]  tone_ctrl;
  logic        fast_clk;
  int unsigned khz_div;
  int unsigned fifty_div;
  int unsigned onehz_div;
  logic [3:0]  sample_div;
  logic [5:0]  irq_flags;
  logic [7:0]  irq_en;

  out_item_t   unit_results_due [$];
  out_item_t   oldest_due;
  int          mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what, input logic [22:0] got,
                                 input logic [22:0] want);
    if (mismatches < 40) begin
      $display("%0t mismatch on %s: got %h, due %h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  function automatic void tone_irq();
    if (irq_en[0]) begin
      irq_flags[IRQ_TONE_LAT] = 1'b1;
    end
    irq_flags[IRQ_TONE_LVL] = ~irq_flags[IRQ_TONE_LVL];
  endfunction

  function automatic out_item_t apply_item(in_item_t it);
    out_item_t  r;
    logic [1:0] sel;
    int         i;
    int         left_sum;
    int         right_sum;
    logic [7:0] keep_a;
    logic [7:0] keep_b;
    r = '0;
    case (it.command)
      CMD_TICK: begin
        sel = tone_ctrl[6:5];
        if (fifty_div == 0) begin
          fifty_div = FiftyReload;
          if (sel == SEL_FIFTY) tone_irq();
        end else begin
          fifty_div = fifty_div - 1;
        end
        if (khz_div == 0) begin
          khz_div = KhzReload;
          if (sel == SEL_KHZ) tone_irq();
        end else begin
          khz_div = khz_div - 1;
        end
        for (i = 0; i < 3; i++) begin
          if (tone_ctrl[i]) begin
            tone_count[i] = {1'b0, tone_reload[i]};
            tone_flip[i] = 1'b0;
          end else if (tone_count[i] == 0) begin
            tone_count[i] = {1'b0, tone_reload[i]};
            tone_flip[i] = ~tone_flip[i];
            if ((i == 0 && sel == SEL_TONE0) || (i == 1 && sel == SEL_TONE1)) tone_irq();
          end else begin
            tone_count[i] = tone_count[i] - 13'd1;
          end
        end
        if (onehz_div == 0) begin
          onehz_div = OneHzReload;
          if (irq_en[2]) irq_flags[IRQ_ONEHZ_LAT] = 1'b1;
          irq_flags[IRQ_ONEHZ_LVL] = ~irq_flags[IRQ_ONEHZ_LVL];
        end else begin
          onehz_div = onehz_div - 1;
        end
        if (sample_en) begin
          if (sample_div == 0) begin
            if (tone_ctrl[3]) begin
              left_sum = int'(volume[0]) * 4;
            end else begin
              left_sum = (tone_flip[0] ? int'(volume[0]) : 0)
                       + (tone_flip[1] ? int'(volume[1]) : 0)
                       + (tone_flip[2] ? int'(volume[2]) : 0);
            end
            if (tone_ctrl[4]) begin
              right_sum = int'(volume[4]) * 4;
            end else begin
              right_sum = (tone_flip[0] ? int'(volume[4]) : 0)
                        + (tone_flip[1] ? int'(volume[5]) : 0)
                        + (tone_flip[2] ? int'(volume[6]) : 0);
            end
            r.sample_valid = 1'b1;
            r.left_sample  = left_sum[7:0];
            r.right_sample = right_sum[7:0];
            sample_div = fast_clk ? 4'(SAMPLE_RELOAD_FAST) : 4'(SAMPLE_RELOAD_SLOW);
          end else begin
            sample_div = sample_div - 4'd1;
          end
        end
      end
      CMD_REG_WRITE: begin
        if (it.reg_offset < OFF_TONE_END) begin
          if (it.reg_offset[0]) begin
            tone_reload[it.reg_offset[2:1]][11:8] = it.write_data[3:0];
          end else begin
            tone_reload[it.reg_offset[2:1]][7:0] = it.write_data;
          end
        end else if (it.reg_offset == OFF_TONE_CTRL) begin
          tone_ctrl = it.write_data[6:0];
        end else if (it.reg_offset >= OFF_VOL_FIRST && it.reg_offset < OFF_VOL_END) begin
          volume[it.reg_offset[2:0]] = it.write_data[5:0];
        end else if (it.reg_offset == OFF_FAST_CLK) begin
          fast_clk = it.write_data[1];
        end
      end
      CMD_IRQ_EN: begin
        irq_en = it.write_data;
        // latch cleared by a one on its own odd bit or by its source's enable bit at zero
        keep_a = 8'h55 | (~it.write_data & 8'hAA);
        keep_b = 8'h55 | ({it.write_data[6:0], 1'b0} & 8'hAA);
        irq_flags = irq_flags & keep_a[5:0] & keep_b[5:0];
      end
      CMD_VIDEO: begin
        if (it.video_level) begin
          irq_flags[IRQ_VIDEO_LVL] = 1'b1;
        end else begin
          if (irq_flags[IRQ_VIDEO_LVL] && irq_en[4]) irq_flags[IRQ_VIDEO_LAT] = 1'b1;
          irq_flags[IRQ_VIDEO_LVL] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    r.int_status = irq_flags;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      sample_en  = 1'b1;
      tone_ctrl  = '0;
      fast_clk   = 1'b0;
      khz_div    = 0;
      fifty_div  = 0;
      onehz_div  = 0;
      sample_div = '0;
      irq_flags  = '0;
      irq_en     = '0;
      for (int k = 0; k < 3; k++) begin
        tone_reload[k] = '0;
        tone_count[k]  = '0;
        tone_flip[k]   = 1'b0;
      end
      for (int k = 0; k < 8; k++) begin
        volume[k] = '0;
      end
      unit_results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        sample_en = cfg_data;
      end
      if (in_valid && !in_stall) begin
        unit_results_due.push_back(apply_item(in_data));
      end
      if (out_valid && !out_stall) begin
        if (unit_results_due.size() == 0) begin
          report_mismatch("result with none due", out_data, '0);
        end else begin
          oldest_due = unit_results_due.pop_front();
          if (out_data.sample_valid !== oldest_due.sample_valid) begin
            report_mismatch("sample_valid", out_data.sample_valid, oldest_due.sample_valid);
          end
          if (out_data.left_sample !== oldest_due.left_sample) begin
            report_mismatch("left_sample", out_data.left_sample, oldest_due.left_sample);
          end
          if (out_data.right_sample !== oldest_due.right_sample) begin
            report_mismatch("right_sample", out_data.right_sample, oldest_due.right_sample);
          end
          if (out_data.int_status !== oldest_due.int_status) begin
            report_mismatch("int_status", out_data.int_status, oldest_due.int_status);
          end
        end
      end
    end
    pending <= unit_results_due.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the tone, timer and interrupt sound unit
// ----------------------------------------------------------------------------
// Drives directed transactions (register map edges, interrupt enables, video
// line edges, sample modes), then random phases under both sample_enable
// settings with random idling on both channels, one long receiver hold-off,
// and one run of back-to-back ticks. A separate checker predicts and
// compares every result; a watchdog ends a hung run.
// ----------------------------------------------------------------------------

module tb;
  import ttisu_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 64;
  localparam int LONG_TICK_RUN  = 60;

  localparam logic [4:0] REG_TONE0_LO  = 5'd0;
  localparam logic [4:0] REG_TONE0_HI  = 5'd1;
  localparam logic [4:0] REG_TONE1_LO  = 5'd2;
  localparam logic [4:0] REG_TONE1_HI  = 5'd3;
  localparam logic [4:0] REG_TONE2_LO  = 5'd4;
  localparam logic [4:0] REG_TONE2_HI  = 5'd5;
  localparam logic [4:0] REG_UNUSED_LO = 5'd6;
  localparam logic [4:0] REG_VOL0      = 5'd8;
  localparam logic [4:0] REG_VOL4      = 5'd12;
  localparam logic [4:0] REG_VOL7      = 5'd15;
  localparam logic [4:0] REG_UNUSED_HI = 5'd16;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  int fail_count;
  int pending;
  int idle_cycles    = 0;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int hold_reqs      = 0;
  int holds_done     = 0;

  tone_timer_interrupt_sound_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ttisu_result_checker result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stall bursts and requested long hold-offs
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        holds_done++;
      end else if ($urandom_range(0, 99) < recv_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_item_t make_item(logic [1:0] cmd, logic [4:0] off,
                                         logic [7:0] data, logic lvl);
    in_item_t it;
    it.command     = cmd;
    it.reg_offset  = off;
    it.write_data  = data;
    it.video_level = lvl;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    int       reg_pick;
    it = make_item(CMD_TICK, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      it.command = CMD_TICK;
    end else if (pick < 85) begin
      it.command = CMD_REG_WRITE;
      reg_pick = $urandom_range(0, 99);
      if (reg_pick < 40) begin
        // small reloads so the tone flip-flops move within the run
        it.reg_offset = 5'($urandom_range(REG_TONE0_LO, REG_TONE2_HI));
        if (it.reg_offset[0]) begin
          if ($urandom_range(0, 3) != 0) it.write_data[3:0] = 4'h0;
        end else if ($urandom_range(0, 1) == 0) begin
          it.write_data = 8'($urandom_range(0, 15));
        end
      end else if (reg_pick < 55) begin
        it.reg_offset = OFF_TONE_CTRL;
        if ($urandom_range(0, 2) != 0) it.write_data[2:0] = 3'b000;
      end else if (reg_pick < 85) begin
        it.reg_offset = 5'($urandom_range(REG_VOL0, REG_VOL7));
      end else if (reg_pick < 92) begin
        it.reg_offset = OFF_FAST_CLK;
      end
    end else if (pick < 92) begin
      it.command = CMD_IRQ_EN;
    end else begin
      it.command = CMD_VIDEO;
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_sample_enable(input logic value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count, input bit calm);
    for (int k = 0; k < count; k++) begin
      if (k % 50 == 0) begin
        send_gap_pct   = calm ? 0 : 15 * $urandom_range(0, 2);
        recv_stall_pct = calm ? 0 : 15 * $urandom_range(0, 2);
      end
      if ($urandom_range(0, 99) < send_gap_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      send_item(random_item());
    end
  endtask

  task automatic run_directed();
    send_item(make_item(CMD_IRQ_EN, 5'd0, 8'hFF, 1'b0));
    // every divider and tone counter expires on the first tick
    send_item(make_item(CMD_TICK, 5'd31, 8'h00, 1'b1));
    send_item(make_item(CMD_VIDEO, 5'd0, 8'h00, 1'b1));
    send_item(make_item(CMD_VIDEO, 5'd0, 8'h00, 1'b0));
    send_item(make_item(CMD_VIDEO, 5'd0, 8'h00, 1'b0));
    send_item(make_item(CMD_REG_WRITE, REG_TONE0_LO, 8'hFF, 1'b0));
    send_item(make_item(CMD_REG_WRITE, REG_TONE0_HI, 8'hFF, 1'b0));
    send_item(make_item(CMD_REG_WRITE, REG_TONE1_LO, 8'h00, 1'b0));
    send_item(make_item(CMD_REG_WRITE, REG_TONE1_HI, 8'h00, 1'b0));
    send_item(make_item(CMD_REG_WRITE, REG_TONE2_LO, 8'h01, 1'b0));
    send_item(make_item(CMD_REG_WRITE, REG_VOL0, 8'hFF, 1'b0));
    send_item(make_item(CMD_REG_WRITE, REG_VOL4, 8'hFF, 1'b0));
    send_item(make_item(CMD_REG_WRITE, REG_VOL7, 8'h2A, 1'b0));
    send_item(make_item(CMD_REG_WRITE, REG_UNUSED_LO, 8'hFF, 1'b0));
    send_item(make_item(CMD_REG_WRITE, REG_UNUSED_HI, 8'hFF, 1'b0));
    send_item(make_item(CMD_REG_WRITE, OFF_FAST_CLK, 8'h02, 1'b0));
    // d/a on both sides, tone 1 as interrupt source
    send_item(make_item(CMD_REG_WRITE, OFF_TONE_CTRL, {1'b1, SEL_TONE1, 5'b11000}, 1'b0));
    repeat (6) send_item(make_item(CMD_TICK, 5'd0, 8'hFF, 1'b0));
    // all sync holds, tone 0 as interrupt source
    send_item(make_item(CMD_REG_WRITE, OFF_TONE_CTRL, {1'b0, SEL_TONE0, 5'b00111}, 1'b0));
    send_item(make_item(CMD_TICK, 5'd0, 8'h00, 1'b0));
    send_item(make_item(CMD_IRQ_EN, 5'd0, 8'h00, 1'b0));
  endtask

  task automatic run_long_ticks();
    in_item_t it;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    send_item(make_item(CMD_IRQ_EN, 5'd0, 8'hFF, 1'b0));
    send_item(make_item(CMD_REG_WRITE, OFF_TONE_CTRL, {1'b0, SEL_FIFTY, 5'b00000}, 1'b0));
    for (int k = 0; k < LONG_TICK_RUN; k++) begin
      it = random_item();
      it.command = CMD_TICK;
      send_item(it);
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    write_sample_enable(1'b1);
    run_directed();
    write_sample_enable(1'b0);
    run_random(200, 1'b0);
    write_sample_enable(1'b1);
    run_random(150, 1'b0);
    hold_reqs++;
    run_random(150, 1'b0);
    run_long_ticks();
    write_sample_enable(1'b0);
    run_random(150, 1'b0);
    write_sample_enable(1'b1);
    run_random(400, 1'b1);
    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
